### rtl/fan_triangulate_dedup_vertices_unit_macros.svh
// Assertion macros used by the checker file of the fan triangulation unit.
`ifndef FAN_TRIANGULATE_DEDUP_VERTICES_UNIT_MACROS_SVH
`define FAN_TRIANGULATE_DEDUP_VERTICES_UNIT_MACROS_SVH

// Asserts that a property holds at every rising edge outside reset.
`define FTDV_ASSERT(lbl, clk_s, rst_n_s, prop) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) prop) \
		else $error("ftdv assertion failed");

// Asserts that a condition never holds at a rising edge outside reset.
`define FTDV_NEVER(lbl, clk_s, rst_n_s, cond) \
	`FTDV_ASSERT(lbl, clk_s, rst_n_s, !(cond))

`endif

### rtl/ftdv_pkg.sv
// Package of constants and types for the fan triangulation unit.
`timescale 1ns / 1ps
`default_nettype none
package ftdv_pkg;

	localparam int MAX_VERTICES_DEF = 1024;
	localparam int INDEX_BITS_DEF   = 16;
	localparam int FIELD_W          = 16;
	localparam int COUNT_W          = 17;
	localparam int VID_W            = 10;

	localparam logic [1:0] KIND_NEW = 2'd0;
	localparam logic [1:0] KIND_TRI = 2'd1;
	localparam logic [1:0] KIND_ERR = 2'd2;

	localparam logic [1:0] ERR_POS  = 2'd0;
	localparam logic [1:0] ERR_TEX  = 2'd1;
	localparam logic [1:0] ERR_NRM  = 2'd2;
	localparam logic [1:0] ERR_FULL = 2'd3;

	localparam logic [1:0] CFG_POS_COUNT = 2'd0;
	localparam logic [1:0] CFG_TEX_COUNT = 2'd1;
	localparam logic [1:0] CFG_NRM_COUNT = 2'd2;

	localparam logic [1:0] CORNER_FIRST  = 2'd0;
	localparam logic [1:0] CORNER_SECOND = 2'd1;
	localparam logic [1:0] CORNER_THIRD  = 2'd2;
	localparam logic [1:0] CORNER_LATER  = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_WAIT   = 4'b0010,
		S_DECIDE = 4'b0100,
		S_TRI    = 4'b1000
	} state_t;

endpackage
`default_nettype wire

### rtl/ftdv_cell.sv
// One cell of the vertex store chain: holds a triple and passes the hit along.
`timescale 1ns / 1ps
`default_nettype none
module ftdv_cell #(
	parameter int CELL_INDEX = 0,
	parameter int KEY_W      = 48,
	parameter int ID_W       = 10
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [KEY_W-1:0]  key,
	input  wire logic [ID_W:0]     total,
	input  wire logic              ins_en,
	input  wire logic              found_in,
	input  wire logic [ID_W-1:0]   id_in,
	output logic                   found_out,
	output logic [ID_W-1:0]        id_out
);

	logic [KEY_W-1:0] triple_q;
	logic             occupied;
	logic             match;

	// Only entries below the vertex count take part in a search.
	assign occupied = (ID_W+1)'(CELL_INDEX) < total;
	assign match    = occupied && (triple_q == key);

	always_ff @(posedge clk) begin
		if (ins_en && (total == (ID_W+1)'(CELL_INDEX))) begin
			triple_q <= key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_out <= 1'b0;
		end else begin
			found_out <= found_in || match;
		end
	end

	always_ff @(posedge clk) begin
		id_out <= found_in ? id_in : ID_W'(CELL_INDEX);
	end

endmodule
`default_nettype wire

### rtl/fan_triangulate_dedup_vertices_unit.sv
// Top level of the fan triangulation unit with vertex deduplication.
`timescale 1ns / 1ps
`default_nettype none
// The unit takes one face corner per input transfer and fan-triangulates each face. Every
// corner triple of a face with three or more corners is looked up in a row of MAX_VERTICES
// store cells; the search key is held steady while a hit flag and its vertex id ripple one
// cell per clock down the row. The first two corners of a face are only held; the third
// corner runs three lookups in turn and every later corner one lookup, and a miss or a
// triangle waits until the consumer has taken the previous result. A miss stores the
// triple in the next free cell and emits a new-vertex record; the triangle follows as the
// last result. An out-of-range index or a full store emits one error, after which input
// transfers are still taken but produce nothing until reset. The count registers may be
// written at any time the unit is idle.
module fan_triangulate_dedup_vertices_unit #(
	parameter int MAX_VERTICES = ftdv_pkg::MAX_VERTICES_DEF,
	parameter int INDEX_BITS   = ftdv_pkg::INDEX_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [16:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [15:0] position_index,
	input  wire logic [15:0] texcoord_index,
	input  wire logic [15:0] normal_index,
	input  wire logic        last_corner,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       kind,
	output logic [9:0]       vertex_a,
	output logic [9:0]       vertex_b,
	output logic [9:0]       vertex_c,
	output logic [15:0]      out_position,
	output logic [15:0]      out_texcoord,
	output logic [15:0]      out_normal,
	output logic [1:0]       error_code,
	output logic             last_result
);

	localparam int IB     = INDEX_BITS;
	localparam int KEY_W  = 3 * IB;
	localparam int ID_W   = $clog2(MAX_VERTICES);
	localparam int CNT_W  = $clog2(MAX_VERTICES + 3);
	localparam int CMP_W  = (IB > ftdv_pkg::COUNT_W) ? IB : ftdv_pkg::COUNT_W;
	localparam int VidW   = ftdv_pkg::VID_W;
	localparam int FieldW = ftdv_pkg::FIELD_W;
	localparam int CountW = ftdv_pkg::COUNT_W;

	// Configuration registers.
	logic [CountW-1:0] pos_count_q, tex_count_q, nrm_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_count_q <= '0;
			tex_count_q <= '0;
			nrm_count_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ftdv_pkg::CFG_POS_COUNT: pos_count_q <= cfg_data;
				ftdv_pkg::CFG_TEX_COUNT: tex_count_q <= cfg_data;
				ftdv_pkg::CFG_NRM_COUNT: nrm_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer state.
	ftdv_pkg::state_t  st_q;
	logic [1:0]        corner_q;
	logic [1:0]        step_q;
	logic              failed_q;
	logic              last_q;
	logic [ID_W:0]     total_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [ID_W-1:0]   c0_q, c1_q, c2_q, centre_q, prev_q;
	logic [KEY_W-1:0]  held0_q, held1_q, cur_q, key_q;

	// Output register.
	logic              out_valid_q;
	logic [1:0]        kind_q, err_q;
	logic [ID_W-1:0]   va_q, vb_q, vc_q;
	logic [KEY_W-1:0]  rec_q;
	logic              last_res_q;

	// Chain of store cells.
	logic              found [0:MAX_VERTICES];
	logic [ID_W-1:0]   ids   [0:MAX_VERTICES];
	logic              ins_en;

	assign found[0] = 1'b0;
	assign ids[0]   = '0;

	for (genvar g = 0; g < MAX_VERTICES; g++) begin : g_cell
		ftdv_cell #(
			.CELL_INDEX(g),
			.KEY_W     (KEY_W),
			.ID_W      (ID_W)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.key      (key_q),
			.total    (total_q),
			.ins_en   (ins_en),
			.found_in (found[g]),
			.id_in    (ids[g]),
			.found_out(found[g+1]),
			.id_out   (ids[g+1])
		);
	end

	logic              hit;
	logic [ID_W-1:0]   hit_id;
	logic [KEY_W-1:0]  in_key;
	logic              can_emit;
	logic              emit;
	logic              has_err;
	logic [1:0]        err_sel;
	logic [IB-1:0]     kp, kt, kn;
	logic              accept;

	assign hit      = found[MAX_VERTICES];
	assign hit_id   = ids[MAX_VERTICES];
	assign in_key   = {IB'(position_index), IB'(texcoord_index), IB'(normal_index)};
	assign can_emit = !out_valid_q || out_ready;
	assign in_ready = (st_q == ftdv_pkg::S_IDLE);
	assign accept   = in_valid && in_ready;
	assign kp       = key_q[KEY_W-1 -: IB];
	assign kt       = key_q[2*IB-1 -: IB];
	assign kn       = key_q[IB-1:0];

	// Range checks in the order position, texcoord, normal, then store capacity.
	always_comb begin
		has_err = 1'b1;
		err_sel = ftdv_pkg::ERR_POS;
		if (CMP_W'(kp) >= CMP_W'(pos_count_q)) begin
			err_sel = ftdv_pkg::ERR_POS;
		end else if (CMP_W'(kt) >= CMP_W'(tex_count_q)) begin
			err_sel = ftdv_pkg::ERR_TEX;
		end else if (CMP_W'(kn) >= CMP_W'(nrm_count_q)) begin
			err_sel = ftdv_pkg::ERR_NRM;
		end else if (total_q == (ID_W+1)'(MAX_VERTICES)) begin
			err_sel = ftdv_pkg::ERR_FULL;
		end else begin
			has_err = 1'b0;
		end
	end

	assign ins_en = (st_q == ftdv_pkg::S_DECIDE) && !hit && !has_err && can_emit;

	// A result is loaded into the output register on a miss (record or error) and for
	// the triangle, whenever the register is free or being emptied in the same cycle.
	assign emit = can_emit &&
		(((st_q == ftdv_pkg::S_DECIDE) && !hit) || (st_q == ftdv_pkg::S_TRI));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ftdv_pkg::S_IDLE;
			corner_q    <= ftdv_pkg::CORNER_FIRST;
			step_q      <= 2'd0;
			failed_q    <= 1'b0;
			last_q      <= 1'b0;
			total_q     <= '0;
			cnt_q       <= '0;
			centre_q    <= '0;
			prev_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				ftdv_pkg::S_IDLE: begin
					if (accept && !failed_q) begin
						last_q <= last_corner;
						case (corner_q)
							ftdv_pkg::CORNER_FIRST: begin
								corner_q <= last_corner ? ftdv_pkg::CORNER_FIRST
									: ftdv_pkg::CORNER_SECOND;
							end
							ftdv_pkg::CORNER_SECOND: begin
								corner_q <= last_corner ? ftdv_pkg::CORNER_FIRST
									: ftdv_pkg::CORNER_THIRD;
							end
							ftdv_pkg::CORNER_THIRD: begin
								step_q <= 2'd0;
								cnt_q  <= '0;
								st_q   <= ftdv_pkg::S_WAIT;
							end
							default: begin
								step_q <= 2'd2;
								cnt_q  <= '0;
								st_q   <= ftdv_pkg::S_WAIT;
							end
						endcase
					end
				end
				ftdv_pkg::S_WAIT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(MAX_VERTICES + 1)) begin
						st_q <= ftdv_pkg::S_DECIDE;
					end
				end
				ftdv_pkg::S_DECIDE: begin
					if (hit || (can_emit && !has_err)) begin
						cnt_q <= '0;
						if (step_q == 2'd2) begin
							st_q <= ftdv_pkg::S_TRI;
						end else begin
							step_q <= step_q + 1'b1;
							st_q   <= ftdv_pkg::S_WAIT;
						end
						if (!hit) begin
							total_q <= total_q + 1'b1;
						end
					end else if (can_emit) begin
						failed_q <= 1'b1;
						st_q     <= ftdv_pkg::S_IDLE;
					end
				end
				ftdv_pkg::S_TRI: begin
					if (can_emit) begin
						if (corner_q == ftdv_pkg::CORNER_THIRD) begin
							centre_q <= c0_q;
						end
						prev_q   <= c2_q;
						corner_q <= last_q ? ftdv_pkg::CORNER_FIRST : ftdv_pkg::CORNER_LATER;
						st_q     <= ftdv_pkg::S_IDLE;
					end
				end
				default: st_q <= ftdv_pkg::S_IDLE;
			endcase
		end
	end

	// Payload registers of the sequencer and the output stage.
	always_ff @(posedge clk) begin
		if (accept && !failed_q) begin
			cur_q <= in_key;
			case (corner_q)
				ftdv_pkg::CORNER_FIRST:  held0_q <= in_key;
				ftdv_pkg::CORNER_SECOND: held1_q <= in_key;
				ftdv_pkg::CORNER_THIRD:  key_q   <= held0_q;
				default: begin
					key_q <= in_key;
					c1_q  <= prev_q;
				end
			endcase
		end
		if ((st_q == ftdv_pkg::S_DECIDE) && (hit || (can_emit && !has_err))) begin
			case (step_q)
				2'd0: begin
					c0_q  <= hit ? hit_id : total_q[ID_W-1:0];
					key_q <= held1_q;
				end
				2'd1: begin
					c1_q  <= hit ? hit_id : total_q[ID_W-1:0];
					key_q <= cur_q;
				end
				default: c2_q <= hit ? hit_id : total_q[ID_W-1:0];
			endcase
		end
		// Records and errors never carry the last-result mark; only the triangle does.
		if ((st_q == ftdv_pkg::S_DECIDE) && !hit && can_emit) begin
			kind_q     <= has_err ? ftdv_pkg::KIND_ERR : ftdv_pkg::KIND_NEW;
			err_q      <= has_err ? err_sel : ftdv_pkg::ERR_POS;
			va_q       <= has_err ? '0 : total_q[ID_W-1:0];
			vb_q       <= '0;
			vc_q       <= '0;
			rec_q      <= has_err ? '0 : key_q;
			last_res_q <= 1'b0;
		end else if ((st_q == ftdv_pkg::S_TRI) && can_emit) begin
			kind_q     <= ftdv_pkg::KIND_TRI;
			err_q      <= ftdv_pkg::ERR_POS;
			va_q       <= (corner_q == ftdv_pkg::CORNER_THIRD) ? c0_q : centre_q;
			vb_q       <= c1_q;
			vc_q       <= c2_q;
			rec_q      <= '0;
			last_res_q <= 1'b1;
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign error_code   = err_q;
	assign vertex_a     = VidW'(va_q);
	assign vertex_b     = VidW'(vb_q);
	assign vertex_c     = VidW'(vc_q);
	assign out_position = FieldW'(rec_q[KEY_W-1 -: IB]);
	assign out_texcoord = FieldW'(rec_q[2*IB-1 -: IB]);
	assign out_normal   = FieldW'(rec_q[IB-1:0]);
	assign last_result  = last_res_q;

endmodule
`default_nettype wire

### rtl/ftdv_checker.sv
// Port-level checker of the fan triangulation unit and its bind statement.
`timescale 1ns / 1ps
`default_nettype none
`include "fan_triangulate_dedup_vertices_unit_macros.svh"
module ftdv_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [1:0] kind,
	input wire logic [1:0] error_code,
	input wire logic       last_result
);

	`FTDV_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(kind))
	`FTDV_NEVER(a_kind_code, clk, arst_n, out_valid && (kind == 2'd3))
	`FTDV_ASSERT(a_err_zero, clk, arst_n, out_valid && (kind != ftdv_pkg::KIND_ERR) |-> error_code == ftdv_pkg::ERR_POS)
	`FTDV_ASSERT(a_err_not_last, clk, arst_n, out_valid && (kind == ftdv_pkg::KIND_ERR) |-> !last_result)
	`FTDV_ASSERT(a_new_not_last, clk, arst_n, out_valid && (kind == ftdv_pkg::KIND_NEW) |-> !last_result)

endmodule

bind fan_triangulate_dedup_vertices_unit ftdv_checker u_ftdv_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.kind       (kind),
	.error_code (error_code),
	.last_result(last_result)
);
`default_nettype wire
